// ----- design/tcsh_pkg.sv -----
// Package for the two-choice string hash bucket block: sizes, codes, beat types.
// No dependencies; every other design file except tcsh_ram imports it.
package tcsh_pkg;

    localparam int BUCKETS    = 1024;
    localparam int COUNT_BITS = 16;

    localparam int IDX_W      = $clog2(BUCKETS);
    localparam int LEN_W      = IDX_W + 1;
    localparam int CFG_W      = 11;
    localparam int HASH_W     = 31;
    localparam int ACC_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int BUCKET_W   = 10;
    localparam int CNT_FLD_W  = 16;

    localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(1024);
    localparam logic [ACC_W-1:0]      BKDR_SEED = ACC_W'(131);
    localparam logic [ACC_W-1:0]      ELF_TOP   = 32'hF000_0000;
    localparam int                    ELF_FOLD  = 24;
    localparam int                    ELF_SHIFT = 4;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // modulo unit: bits retired per cycle and cycles per reduction
    localparam int DIV_STEP   = 8;
    localparam int DIV_W      = ACC_W;
    localparam int DIV_CYCLES = DIV_W / DIV_STEP;
    localparam int CYC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] key_byte;
        logic              last;
    } in_beat_t;

    typedef struct packed {
        logic [BUCKET_W-1:0]  bucket;
        logic                 occupied;
        logic [CNT_FLD_W-1:0] bucket_count;
        logic [HASH_W-1:0]    hash_first;
        logic [HASH_W-1:0]    hash_second;
    } out_beat_t;

    // one accepted key byte as seen by the hash unit
    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] key_byte;
        logic              last;
    } hash_step_t;

endpackage

// ----- design/tcsh_ram.sv -----
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
module tcsh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/tcsh_hash.sv -----
// Running BKDR and ELF hash accumulators, one key byte per beat.
// Depends on tcsh_pkg.
module tcsh_hash (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tcsh_pkg::hash_step_t       step,
    output logic [tcsh_pkg::HASH_W-1:0] hash_first,
    output logic [tcsh_pkg::HASH_W-1:0] hash_second
);
    import tcsh_pkg::*;

    logic [ACC_W-1:0] bkdr_reg, bkdr_next;
    logic [ACC_W-1:0] elf_reg, elf_next;
    logic [ACC_W-1:0] bkdr_sum, elf_sum, elf_top;

    always_comb
    begin
        bkdr_sum = bkdr_reg * BKDR_SEED + ACC_W'(step.key_byte);
        elf_sum  = (elf_reg << ELF_SHIFT) + ACC_W'(step.key_byte);
        elf_top  = elf_sum & ELF_TOP;
        // fold is a no-op when the top nibble is clear
        elf_sum  = (elf_sum ^ (elf_top >> ELF_FOLD)) & ~elf_top;

        bkdr_next = bkdr_reg;
        elf_next  = elf_reg;
        if (step.en)
        begin
            bkdr_next = step.last ? '0 : bkdr_sum;
            elf_next  = step.last ? '0 : elf_sum;
        end
    end

    assign hash_first  = bkdr_sum[HASH_W-1:0];
    assign hash_second = elf_sum[HASH_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bkdr_reg <= '0;
            elf_reg  <= '0;
        end
        else
        begin
            bkdr_reg <= bkdr_next;
            elf_reg  <= elf_next;
        end
    end

endmodule

// ----- design/tcsh_mod.sv -----
// Multi-cycle modulo unit: restoring remainder, DIV_STEP dividend bits per cycle.
// Depends on tcsh_pkg.
module tcsh_mod (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tcsh_pkg::DIV_W-1:0] dividend,
    input  logic [tcsh_pkg::LEN_W-1:0] divisor,
    output logic                       done,
    output logic [tcsh_pkg::IDX_W-1:0] rem
);
    import tcsh_pkg::*;

    logic [DIV_W-1:0] dvd_reg;
    logic [LEN_W-1:0] dvs_reg;
    logic [IDX_W-1:0] rem_reg;
    logic [CYC_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [IDX_W-1:0] rem_step;

    // remainder stays below the divisor, so one subtract per bit suffices
    always_comb
    begin
        logic [LEN_W-1:0] trial;
        rem_step = rem_reg;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_step, dvd_reg[DIV_W-1-i]};
            if (trial >= dvs_reg)
            begin
                trial = trial - dvs_reg;
            end
            rem_step = trial[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CYC_W'(1);
                if (cnt_reg == CYC_W'(DIV_CYCLES - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << DIV_STEP;
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// ----- design/two_choice_string_hash_bucket_top.sv -----
// Two-choice string hash bucket selector, top level.
// Non-final key bytes: one beat per cycle. A final byte stalls input while the two parallel
// modulo units reduce (DIV_STEP bits per cycle), 2 count reads use the single RAM read port, and
// the pick and write back wait for a free output slot; the result beat is registered.
// Reset: asynchronous, active low; a clearing pass then zeroes all BUCKETS (1024)
// count entries, one per cycle, with input stalled. Config writes are taken always.
module two_choice_string_hash_bucket_top (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [tcsh_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  tcsh_pkg::in_beat_t        in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output tcsh_pkg::out_beat_t       out_data
);
    import tcsh_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_RD1,
        S_RD2,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_addr_reg, clr_addr_next;
    logic [CFG_W-1:0]      len_cfg_reg;
    logic                  op_reg, op_next;
    logic [HASH_W-1:0]     h1_reg, h1_next;
    logic [HASH_W-1:0]     h2_reg, h2_next;
    logic [COUNT_BITS-1:0] c1_reg, c1_next;
    logic                  out_valid_reg, out_valid_next;
    out_beat_t             out_reg, out_next;

    // input beat and hash unit
    logic              in_fire;
    hash_step_t        step;
    logic [HASH_W-1:0] hash_first, hash_second;

    // modulo units
    logic             mod_start;
    logic [LEN_W-1:0] len_eff;
    logic             done_first, done_second;
    logic [IDX_W-1:0] idx_first, idx_second;

    // count memory
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

    // bucket choice
    logic                  out_free;
    logic [IDX_W-1:0]      pick;
    logic [COUNT_BITS-1:0] pick_cnt;
    logic                  pick_occ;
    logic [COUNT_BITS-1:0] c2;
    logic [31:0]           len_wide, pick_wide, cnt_wide;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign mod_start = in_fire && in_data.last;
    assign out_free  = !out_valid_reg || !out_stall;

    assign step.en       = in_fire;
    assign step.key_byte = in_data.key_byte;
    assign step.last     = in_data.last;

    // zero length acts as 1, anything above BUCKETS as BUCKETS
    always_comb
    begin
        len_wide = 32'(len_cfg_reg);
        if (len_wide == 32'd0)
        begin
            len_wide = 32'd1;
        end
        else if (len_wide > 32'(BUCKETS))
        begin
            len_wide = 32'(BUCKETS);
        end
        len_eff = len_wide[LEN_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            len_cfg_reg <= cfg_wr_data;
        end
    end

    tcsh_hash u_hash (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .hash_first  (hash_first),
        .hash_second (hash_second)
    );

    tcsh_mod u_mod_first (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (DIV_W'(hash_first)),
        .divisor  (len_eff),
        .done     (done_first),
        .rem      (idx_first)
    );

    tcsh_mod u_mod_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (DIV_W'(hash_second)),
        .divisor  (len_eff),
        .done     (done_second),
        .rem      (idx_second)
    );

    tcsh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BUCKETS)
    ) u_counts (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // In S_DONE the read port holds the second bucket's count; c1_reg has the first's.
    always_comb
    begin
        c2       = ram_rdata;
        pick     = idx_first;
        pick_cnt = c1_reg;
        pick_occ = 1'b1;
        if (op_reg == OP_INSERT)
        begin
            if (c1_reg != '0 && c2 < c1_reg)
            begin
                pick     = idx_second;
                pick_cnt = c2;
            end
            if (pick_cnt != COUNT_MAX)
            begin
                pick_cnt = pick_cnt + COUNT_BITS'(1);
            end
        end
        else if (c1_reg == '0)
        begin
            if (c2 != '0)
            begin
                pick     = idx_second;
                pick_cnt = c2;
            end
            else
            begin
                pick     = '0;
                pick_cnt = '0;
                pick_occ = 1'b0;
            end
        end
        pick_wide = 32'(pick);
        cnt_wide  = 32'(pick_cnt);
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        op_next        = op_reg;
        h1_next        = h1_reg;
        h2_next        = h2_reg;
        c1_next        = c1_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_addr_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = idx_first;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we        = 1'b1;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == IDX_W'(BUCKETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (mod_start)
                begin
                    op_next    = in_data.op;
                    h1_next    = hash_first;
                    h2_next    = hash_second;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (done_first)
                begin
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_first;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_second;
                c1_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ram_we                = (op_reg == OP_INSERT);
                    ram_waddr             = pick;
                    ram_wdata             = pick_cnt;
                    out_valid_next        = 1'b1;
                    out_next.bucket       = pick_wide[BUCKET_W-1:0];
                    out_next.occupied     = pick_occ;
                    out_next.bucket_count = cnt_wide[CNT_FLD_W-1:0];
                    out_next.hash_first   = h1_reg;
                    out_next.hash_second  = h2_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            op_reg        <= OP_INSERT;
            h1_reg        <= '0;
            h2_reg        <= '0;
            c1_reg        <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            op_reg        <= op_next;
            h1_reg        <= h1_next;
            h2_reg        <= h2_next;
            c1_reg        <= c1_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // both reductions start together and must finish together
    a_mod_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done_first == done_second)
        else $error("modulo units out of step");

    // outside the clearing pass, counts change only on an insert being retired
    a_write_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg != S_CLEAR) |-> (state_reg == S_DONE && op_reg == OP_INSERT))
        else $error("count write outside insert");

    // a lookup miss reports bucket 0 with count 0; any hit has a nonzero count
    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.occupied == (out_data.bucket_count != '0 || COUNT_BITS > CNT_FLD_W))
            || (out_data.occupied && out_data.bucket_count == '0))
        else $error("occupied flag disagrees with count");

    // a key end is accepted only when no other key is in flight
    a_one_key: assert property (@(posedge clk) disable iff (!rst_n)
        mod_start |=> (state_reg == S_DIV && in_stall))
        else $error("key end not held off");

endmodule
